// ===== hdl/pcg32_pkg.sv =====
// Shared constants and types for the PCG32 XSH-RR random generator.
`default_nettype none
package pcg32_pkg;

	localparam int unsigned STATE_W    = 64;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned SEQ_W      = 63;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned IDX_W      = 1;

	localparam logic [STATE_W-1:0] PCG_MULT = 64'd6364136223846793005;
	localparam int unsigned XSH_SHIFT  = 18;
	localparam int unsigned XSH_SELECT = 27;
	localparam int unsigned ROT_POS    = 59;
	localparam int unsigned ROT_W      = 5;

	localparam logic [STATE_W-1:0] LCG_STATE_RESET = 64'h853c49e6748fea9b;
	localparam logic [STATE_W-1:0] LCG_INC_RESET   = 64'hda3e39cb94b95bdb;

	localparam int unsigned LCG_DIGIT_W = 4;
	localparam int unsigned LCG_STEPS   = STATE_W / LCG_DIGIT_W;
	localparam int unsigned LCG_CNT_W   = $clog2(LCG_STEPS);
	localparam int unsigned MOD_CNT_W   = $clog2(WORD_W);

	localparam logic [CMD_W-1:0] CMD_RAW     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BOUNDED = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESEED  = 2'd2;

	localparam logic [IDX_W-1:0] REG_SEED_STATE    = 1'd0;
	localparam logic [IDX_W-1:0] REG_SEED_SEQUENCE = 1'd1;

	typedef struct packed {
		logic advance;
		logic clear;
		logic add_seed;
	} lcg_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/pcg32_random_generator_top.sv =====
// A raw word is offered once its digit-serial LCG advance is done.
// A bounded draw finds the threshold, redraws words below it, then takes the remainder.
// Reseed clears, advances, adds the seed, advances; a zero bound or unused code just finishes.
// One command is worked on at a time; the next is taken while the previous result still waits.
// Reset is asynchronous and active low; it restores the default LCG state and increment.
`default_nettype none
module pcg32_random_generator_top (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [pcg32_pkg::WORD_W-1:0]      s_tdata,  // bound
	input  wire  [pcg32_pkg::CMD_W-1:0]       s_tuser,  // command
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [pcg32_pkg::WORD_W-1:0]      m_tdata,  // value
	output logic [0:0]                        m_tuser,  // bad_bound
	input  wire                               wr_en,
	input  wire  [pcg32_pkg::IDX_W-1:0]       wr_index,
	input  wire  [pcg32_pkg::STATE_W-1:0]     wr_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RAW, ST_THR, ST_DRAW, ST_REM,
		ST_RS_A, ST_RS_B, ST_RS_C, ST_RS_D, ST_FIN
	} state_t;

	state_t                           state_q;
	logic [pcg32_pkg::STATE_W-1:0]    seed_state_q;
	logic [pcg32_pkg::SEQ_W-1:0]      seed_seq_q;
	logic [pcg32_pkg::WORD_W-1:0]     bound_q;
	logic [pcg32_pkg::WORD_W-1:0]     thr_q;
	logic [pcg32_pkg::WORD_W-1:0]     res_value_q;
	logic                             res_bad_q;
	logic                             m_tvalid_q;
	logic [pcg32_pkg::WORD_W-1:0]     m_tdata_q;
	logic                             m_tuser_q;

	pcg32_pkg::lcg_cmd_t              lcg_cmd;
	logic [pcg32_pkg::WORD_W-1:0]     lcg_word;
	logic                             lcg_done;
	logic                             mod_start;
	logic [pcg32_pkg::WORD_W-1:0]     mod_dividend;
	logic [pcg32_pkg::WORD_W-1:0]     mod_divisor;
	logic [pcg32_pkg::WORD_W-1:0]     mod_rem;
	logic                             mod_done;
	logic                             accept;
	logic                             below_thr;
	logic                             out_load;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign below_thr = (lcg_word < thr_q);
	assign out_load  = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_state_q <= '0;
			seed_seq_q   <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				pcg32_pkg::REG_SEED_STATE:    seed_state_q <= wr_data;
				pcg32_pkg::REG_SEED_SEQUENCE: seed_seq_q   <= wr_data[pcg32_pkg::SEQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		lcg_cmd      = '0;
		mod_start    = 1'b0;
		mod_dividend = lcg_word;
		mod_divisor  = bound_q;
		unique case (state_q)
			ST_IDLE: begin
				mod_dividend = '0 - s_tdata;
				mod_divisor  = s_tdata;
				if (accept) begin
					lcg_cmd.advance = (s_tuser == pcg32_pkg::CMD_RAW);
					lcg_cmd.clear   = (s_tuser == pcg32_pkg::CMD_RESEED);
					mod_start       = (s_tuser == pcg32_pkg::CMD_BOUNDED) && (s_tdata != '0);
				end
			end
			ST_THR:  lcg_cmd.advance = mod_done;
			ST_DRAW: begin
				lcg_cmd.advance = lcg_done && below_thr;
				mod_start       = lcg_done && !below_thr;
			end
			ST_RS_A: lcg_cmd.advance  = 1'b1;
			ST_RS_B: lcg_cmd.add_seed = lcg_done;
			ST_RS_C: lcg_cmd.advance  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bound_q     <= '0;
			thr_q       <= '0;
			res_value_q <= '0;
			res_bad_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= res_value_q;
				m_tuser_q  <= res_bad_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bound_q     <= s_tdata;
						res_value_q <= '0;
						res_bad_q   <= 1'b0;
						unique case (s_tuser)
							pcg32_pkg::CMD_RAW:    state_q <= ST_RAW;
							pcg32_pkg::CMD_BOUNDED: begin
								if (s_tdata == '0) begin
									res_bad_q <= 1'b1;
									state_q   <= ST_FIN;
								end else begin
									state_q <= ST_THR;
								end
							end
							pcg32_pkg::CMD_RESEED: state_q <= ST_RS_A;
							default:               state_q <= ST_FIN;
						endcase
					end
				end
				ST_RAW: begin
					if (lcg_done) begin
						res_value_q <= lcg_word;
						state_q     <= ST_FIN;
					end
				end
				ST_THR: begin
					if (mod_done) begin
						thr_q   <= mod_rem;
						state_q <= ST_DRAW;
					end
				end
				ST_DRAW: begin
					if (lcg_done && !below_thr) begin
						state_q <= ST_REM;
					end
				end
				ST_REM: begin
					if (mod_done) begin
						res_value_q <= mod_rem;
						state_q     <= ST_FIN;
					end
				end
				ST_RS_A: state_q <= ST_RS_B;
				ST_RS_B: begin
					if (lcg_done) begin
						state_q <= ST_RS_C;
					end
				end
				ST_RS_C: state_q <= ST_RS_D;
				ST_RS_D: begin
					if (lcg_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	pcg32_lcg u_lcg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (lcg_cmd),
		.seed_state    (seed_state_q),
		.seed_sequence (seed_seq_q),
		.word          (lcg_word),
		.done          (lcg_done)
	);

	pcg32_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (mod_divisor),
		.rem      (mod_rem),
		.done     (mod_done)
	);

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

endmodule
`default_nettype wire

// ===== hdl/pcg32_lcg.sv =====
// Digit-serial LCG advance with XSH-RR output permutation.
`default_nettype none
module pcg32_lcg (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  pcg32_pkg::lcg_cmd_t           cmd,
	input  wire  [pcg32_pkg::STATE_W-1:0]       seed_state,
	input  wire  [pcg32_pkg::SEQ_W-1:0]         seed_sequence,
	output logic [pcg32_pkg::WORD_W-1:0]        word,
	output logic                                done
);

	logic [pcg32_pkg::STATE_W-1:0]   state_q;
	logic [pcg32_pkg::STATE_W-1:0]   inc_q;
	logic [pcg32_pkg::STATE_W-1:0]   mplier_q;
	logic [pcg32_pkg::STATE_W-1:0]   mcand_q;
	logic [pcg32_pkg::LCG_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [pcg32_pkg::WORD_W-1:0]    word_q;
	logic [pcg32_pkg::STATE_W-1:0]   partial;

	function automatic logic [pcg32_pkg::WORD_W-1:0] permute(
		input logic [pcg32_pkg::STATE_W-1:0] old
	);
		logic [pcg32_pkg::STATE_W-1:0] mixed;
		logic [pcg32_pkg::WORD_W-1:0]  x;
		logic [pcg32_pkg::ROT_W-1:0]   rot;
		logic [pcg32_pkg::ROT_W-1:0]   rot_neg;
		mixed   = (old >> pcg32_pkg::XSH_SHIFT) ^ old;
		x       = mixed[pcg32_pkg::XSH_SELECT +: pcg32_pkg::WORD_W];
		rot     = old[pcg32_pkg::ROT_POS +: pcg32_pkg::ROT_W];
		rot_neg = ~rot + 5'd1;
		return (x >> rot) | (x << rot_neg);
	endfunction

	assign partial = mcand_q *
		{{(pcg32_pkg::STATE_W-pcg32_pkg::LCG_DIGIT_W){1'b0}},
		 mplier_q[pcg32_pkg::LCG_DIGIT_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pcg32_pkg::LCG_STATE_RESET;
			inc_q    <= pcg32_pkg::LCG_INC_RESET;
			mplier_q <= '0;
			mcand_q  <= '0;
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			word_q   <= '0;
		end else begin
			done_q <= 1'b0;
			priority if (cmd.clear) begin
				state_q <= '0;
				inc_q   <= {seed_sequence, 1'b1};
			end else if (cmd.add_seed) begin
				state_q <= state_q + seed_state;
			end else if (cmd.advance) begin
				mplier_q <= state_q;
				mcand_q  <= pcg32_pkg::PCG_MULT;
				state_q  <= inc_q | {{(pcg32_pkg::STATE_W-1){1'b0}}, 1'b1};
				word_q   <= permute(state_q);
				cnt_q    <= '0;
				busy_q   <= 1'b1;
			end else if (busy_q) begin
				state_q  <= state_q + partial;
				mplier_q <= mplier_q >> pcg32_pkg::LCG_DIGIT_W;
				mcand_q  <= mcand_q << pcg32_pkg::LCG_DIGIT_W;
				cnt_q    <= cnt_q + 1'b1;
				if (cnt_q == pcg32_pkg::LCG_CNT_W'(pcg32_pkg::LCG_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign word = word_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ===== hdl/pcg32_mod.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module pcg32_mod (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	input  wire  [pcg32_pkg::WORD_W-1:0]        dividend,
	input  wire  [pcg32_pkg::WORD_W-1:0]        divisor,
	output logic [pcg32_pkg::WORD_W-1:0]        rem,
	output logic                                done
);

	logic [pcg32_pkg::WORD_W-1:0]    a_q;
	logic [pcg32_pkg::WORD_W-1:0]    d_q;
	logic [pcg32_pkg::WORD_W-1:0]    rem_q;
	logic [pcg32_pkg::MOD_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [pcg32_pkg::WORD_W:0]      trial;
	logic [pcg32_pkg::WORD_W:0]      diff;

	assign trial = {rem_q, a_q[pcg32_pkg::WORD_W-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			d_q    <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= dividend;
				d_q    <= divisor;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (trial >= {1'b0, d_q}) begin
					rem_q <= diff[pcg32_pkg::WORD_W-1:0];
				end else begin
					rem_q <= trial[pcg32_pkg::WORD_W-1:0];
				end
				a_q   <= a_q << 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pcg32_pkg::MOD_CNT_W'(pcg32_pkg::WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ===== hdl/pcg32_checker.sv =====
// Port-level checks for the PCG32 generator, bound to the top level.
`default_nettype none
module pcg32_port_checks (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               s_tvalid,
	input wire                               s_tready,
	input wire [pcg32_pkg::WORD_W-1:0]       s_tdata,
	input wire [pcg32_pkg::CMD_W-1:0]        s_tuser,
	input wire                               m_tvalid,
	input wire                               m_tready,
	input wire [pcg32_pkg::WORD_W-1:0]       m_tdata,
	input wire [0:0]                         m_tuser,
	input wire                               wr_en,
	input wire [pcg32_pkg::IDX_W-1:0]        wr_index,
	input wire [pcg32_pkg::STATE_W-1:0]      wr_data
);

	logic unused_ok;
	assign unused_ok = ^{s_tdata, s_tuser, wr_en, wr_index, wr_data};

	// A stalled result word holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// A bad bound always comes with a zero value.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("bad bound reported with nonzero value");

	// Only one command is in flight, so ready drops after each accepted word.
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an accepted word");

	// A result cannot appear in the cycle after an accept from an empty output.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result offered too early");

endmodule

bind pcg32_random_generator_top pcg32_port_checks u_pcg32_checker (.*);
`default_nettype wire

// ===== bench/pcg32_checker.sv =====
// Checker that predicts each PCG32 result word and compares it with the block's output.
module pcg32_checker
	import pcg32_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	input  wire                  s_tready,
	input  wire  [WORD_W-1:0]    s_tdata,
	input  wire  [CMD_W-1:0]     s_tuser,
	input  wire                  m_tvalid,
	input  wire                  m_tready,
	input  wire  [WORD_W-1:0]    m_tdata,
	input  wire  [0:0]           m_tuser,
	input  wire                  wr_en,
	input  wire  [IDX_W-1:0]     wr_index,
	input  wire  [STATE_W-1:0]   wr_data,
	output int                   fail_count,
	output int                   pending_count
);

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              bad_bound;
	} draw_t;

	logic [STATE_W-1:0] lcg_state;
	logic [STATE_W-1:0] lcg_inc;
	logic [STATE_W-1:0] seed_state;
	logic [SEQ_W-1:0]   seed_seq;
	draw_t              expected_draws[$];

	function automatic logic [WORD_W-1:0] advance_lcg();
		logic [STATE_W-1:0]  old;
		logic [STATE_W-1:0]  shifted;
		logic [ROT_W-1:0]    rot;
		logic [2*WORD_W-1:0] doubled;
		old = lcg_state;
		lcg_state = old * PCG_MULT + (lcg_inc | 64'd1);
		shifted = ((old >> XSH_SHIFT) ^ old) >> XSH_SELECT;
		rot = old[ROT_POS +: ROT_W];
		doubled = {shifted[WORD_W-1:0], shifted[WORD_W-1:0]} >> rot;
		return doubled[WORD_W-1:0];
	endfunction

	function automatic draw_t predict_draw(input logic [CMD_W-1:0] cmd,
			input logic [WORD_W-1:0] bound);
		draw_t             d;
		logic [WORD_W-1:0] threshold;
		logic [WORD_W-1:0] word;
		d = '0;
		case (cmd)
			CMD_RAW: begin
				d.value = advance_lcg();
			end
			CMD_BOUNDED: begin
				if (bound == '0) begin
					d.bad_bound = 1'b1;
				end else begin
					threshold = (32'd0 - bound) % bound;
					do
						word = advance_lcg();
					while (word < threshold);
					d.value = word % bound;
				end
			end
			CMD_RESEED: begin
				lcg_state = '0;
				lcg_inc = {seed_seq, 1'b1};
				void'(advance_lcg());
				lcg_state = lcg_state + seed_state;
				void'(advance_lcg());
			end
			default: begin
			end
		endcase
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		draw_t want;
		if (!arst_n) begin
			lcg_state = LCG_STATE_RESET;
			lcg_inc = LCG_INC_RESET;
			seed_state = '0;
			seed_seq = '0;
			expected_draws.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_SEED_STATE)
					seed_state = wr_data;
				else if (wr_index == REG_SEED_SEQUENCE)
					seed_seq = wr_data[SEQ_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				if (expected_draws.size() == 0) begin
					$error("result word with none expected: value %h bad_bound %b",
						m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = expected_draws.pop_front();
					if (m_tdata !== want.value) begin
						$error("value: expected %h, got %h", want.value, m_tdata);
						fail_count++;
					end
					if (m_tuser[0] !== want.bad_bound) begin
						$error("bad_bound: expected %b, got %b", want.bad_bound, m_tuser[0]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_draws.push_back(predict_draw(s_tuser, s_tdata));
			pending_count = expected_draws.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// Top-level testbench that drives commands and seed writes into the PCG32 generator.
module tb;
	import pcg32_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_WORDS = 360;
	localparam int SETTLE       = 40;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [WORD_W-1:0]   s_tdata;
	logic [CMD_W-1:0]    s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [WORD_W-1:0]   m_tdata;
	logic [0:0]          m_tuser;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_index;
	logic [STATE_W-1:0]  wr_data;
	int                  fail_count;
	int                  pending_count;
	int                  send_idle_pct;
	int                  recv_stall_pct;
	int                  hold_cycles;
	int                  cycle_count = 0;

	pcg32_random_generator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	pcg32_checker draw_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL pcg32_random_generator_top");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] bound);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= bound;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_random();
		int                pick;
		logic [WORD_W-1:0] bound;
		pick = $urandom_range(99);
		bound = $urandom;
		if (pick < 35) begin
			send_word(CMD_RAW, bound);
		end else if (pick < 80) begin
			case ($urandom_range(3))
				0: bound = $urandom_range(16, 1);
				1: bound = 32'h8000_0000 + $urandom_range(64);
				2: bound = ~$urandom_range(64);
				default: begin
				end
			endcase
			send_word(CMD_BOUNDED, bound);
		end else if (pick < 88) begin
			send_word(CMD_RESEED, bound);
		end else if (pick < 94) begin
			send_word(CMD_BOUNDED, '0);
		end else begin
			send_word(CMD_UNUSED, bound);
		end
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [STATE_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_RAW;
		m_tready = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_SEED_STATE;
		wr_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The first words come from the default state and stream.
		send_word(CMD_RAW, '0);
		send_word(CMD_RAW, '1);
		send_word(CMD_BOUNDED, 32'd1);
		send_word(CMD_BOUNDED, 32'd2);
		send_word(CMD_BOUNDED, 32'd3);
		send_word(CMD_BOUNDED, 32'd7);
		send_word(CMD_BOUNDED, 32'h8000_0000);
		send_word(CMD_BOUNDED, 32'h8000_0001);
		send_word(CMD_BOUNDED, 32'hFFFF_FFFF);
		send_word(CMD_BOUNDED, '0);
		send_word(CMD_UNUSED, '1);
		send_word(CMD_UNUSED, '0);
		send_word(CMD_RAW, 32'h5555_5555);
		send_word(CMD_RESEED, '1);
		send_word(CMD_RAW, 32'hAAAA_AAAA);
		wait_drained();

		// All-ones seeds also check that the top bit of the stream selector is dropped.
		write_reg(REG_SEED_STATE, '1);
		write_reg(REG_SEED_SEQUENCE, '1);
		send_word(CMD_RESEED, '0);
		send_word(CMD_RAW, '0);
		send_word(CMD_BOUNDED, 32'hFFFF_FFFF);
		send_word(CMD_BOUNDED, 32'd1);
		send_word(CMD_BOUNDED, '0);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					write_reg(REG_SEED_STATE, {$urandom, $urandom});
					write_reg(REG_SEED_SEQUENCE, {$urandom, $urandom});
				end
				1: begin
					send_idle_pct = 52;
					recv_stall_pct = 0;
					write_reg(REG_SEED_STATE, '0);
					write_reg(REG_SEED_SEQUENCE, {1'b0, {SEQ_W{1'b1}}});
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 52;
					write_reg(REG_SEED_STATE, '1);
					write_reg(REG_SEED_SEQUENCE, '0);
				end
				default: begin
					send_idle_pct = 38;
					recv_stall_pct = 38;
					write_reg(REG_SEED_STATE, {$urandom, $urandom});
					write_reg(REG_SEED_SEQUENCE, {$urandom, $urandom});
				end
			endcase
			send_word(CMD_RESEED, $urandom);
			for (int n = 0; n < RANDOM_WORDS; n++) begin
				if (ph == 1 && n == 150)
					wait_drained();
				if (ph == 2 && n == 100)
					hold_cycles = 600;
				send_random();
			end
			wait_drained();
		end

		if (fail_count == 0)
			$display("PASS pcg32_random_generator_top");
		else
			$display("FAIL pcg32_random_generator_top");
		$finish;
	end

endmodule
